FILE: sv/bfm_pkg.sv
`default_nettype none

package bfm_pkg;

  // Field and register widths.
  localparam int unsigned PIX_W = 8;
  localparam int unsigned DIM_W = 13;
  localparam int unsigned ROW_W = 12;
  localparam int unsigned SQ_W  = 16;
  localparam int unsigned SUM_W = 40;
  localparam int unsigned CNT_W = 24;

  // Rows per frame are capped at this height.
  localparam int unsigned MAX_HEIGHT = 4096;

  // Configuration register indexes and reset values.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;
  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // Bookkeeping that travels with one pixel.
  typedef struct packed {
    logic             term_en;
    logic             frame_end;
    logic             too_small;
    logic [CNT_W-1:0] count;
  } frame_info_t;

  // Gradient stage contents handed to the accumulator.
  typedef struct packed {
    logic             valid;
    logic [SQ_W-1:0]  sq;
    frame_info_t      info;
  } grad_t;

endpackage

`default_nettype wire

FILE: sv/bfm_scan.sv
`default_nettype none

module bfm_scan #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned AW        = $clog2(MAX_WIDTH)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bfm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [bfm_pkg::DIM_W-1:0]      cfg_data_i,
  input  wire logic                           accept_i,
  output logic [AW-1:0]                       col_o,
  output logic [AW-1:0]                       rd_addr_o,
  output logic [AW-1:0]                       rd_addr2_o,
  output bfm_pkg::frame_info_t                info_o
);
  import bfm_pkg::*;

  logic [DIM_W-1:0] width_q, height_q;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [AW-1:0]    col_q, col_d, col_inc;
  logic [ROW_W-1:0] row_q, row_d;
  logic             last_col, last_row;
  logic [2*DIM_W-1:0] product;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_WIDTH_RST;
      height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective dimensions: zero reads as one, large values are capped.
  always_comb begin
    if (width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  // Position within the frame and the flags of the current pixel.
  assign last_col = (32'(col_q) + 32'd1) >= 32'(w_eff);
  assign last_row = (32'(row_q) + 32'd1) >= 32'(h_eff);
  assign col_inc  = col_q + AW'(1);
  assign product  = (2*DIM_W)'(w_eff - DIM_W'(2)) * (2*DIM_W)'(h_eff - DIM_W'(2));

  always_comb begin
    info_o.term_en   = (row_q >= ROW_W'(2)) && ((32'(col_q) + 32'd2) < 32'(w_eff));
    info_o.frame_end = last_col && last_row;
    info_o.too_small = (w_eff < DIM_W'(4)) || (h_eff < DIM_W'(4));
    info_o.count     = info_o.too_small ? '0 : product[CNT_W-1:0];
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line buffer reads are issued for the position of the next pixel.
  assign col_o      = col_q;
  assign rd_addr_o  = col_d;
  assign rd_addr2_o = ((32'(col_d) + 32'd2) < MAX_WIDTH) ? col_d + AW'(2) : '0;

  // The column never leaves the line buffer.
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < MAX_WIDTH)
    else $error("column position beyond line buffer depth");

endmodule

`default_nettype wire

FILE: sv/bfm_line_buffers.sv
`default_nettype none

module bfm_line_buffers #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned AW        = $clog2(MAX_WIDTH)
) (
  input  wire logic                      clk_i,
  input  wire logic                      wr_en_i,
  input  wire logic [AW-1:0]             wr_addr_i,
  input  wire logic [bfm_pkg::PIX_W-1:0] pixel_i,
  input  wire logic [AW-1:0]             rd_addr_i,
  input  wire logic [AW-1:0]             rd_addr2_i,
  output logic [bfm_pkg::PIX_W-1:0]      two_back_o,
  output logic [bfm_pkg::PIX_W-1:0]      two_ahead_o
);
  import bfm_pkg::*;

  logic [PIX_W-1:0] line_one_mem [MAX_WIDTH];
  logic [PIX_W-1:0] line_two_mem [MAX_WIDTH];
  logic [PIX_W-1:0] one_back_q;
  logic [PIX_W-1:0] two_back_q;
  logic [PIX_W-1:0] two_ahead_q;

  // Row above: written with the new pixel, read at the next column.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      line_one_mem[wr_addr_i] <= pixel_i;
    end
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      one_back_q <= pixel_i;
    end else begin
      one_back_q <= line_one_mem[rd_addr_i];
    end
  end

  // Two rows above: takes over the old row-above entry; two read ports.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      line_two_mem[wr_addr_i] <= one_back_q;
    end
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      two_back_q <= one_back_q;
    end else begin
      two_back_q <= line_two_mem[rd_addr_i];
    end
    if (wr_en_i && (wr_addr_i == rd_addr2_i)) begin
      two_ahead_q <= one_back_q;
    end else begin
      two_ahead_q <= line_two_mem[rd_addr2_i];
    end
  end

  assign two_back_o  = two_back_q;
  assign two_ahead_o = two_ahead_q;

endmodule

`default_nettype wire

FILE: sv/bfm_gradient.sv
`default_nettype none

module bfm_gradient (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic                      advance_i,
  input  wire logic [bfm_pkg::PIX_W-1:0] pixel_i,
  input  wire logic [bfm_pkg::PIX_W-1:0] base_i,
  input  wire logic [bfm_pkg::PIX_W-1:0] right_i,
  input  wire bfm_pkg::frame_info_t      info_i,
  output bfm_pkg::grad_t                 grad_o
);
  import bfm_pkg::*;

  logic [PIX_W-1:0] dh, dv, dmax;
  logic [SQ_W-1:0]  sq_q;
  frame_info_t      info_q;
  logic             valid_q;

  // Larger of the horizontal and vertical distance-two differences, squared.
  always_comb begin
    dh   = (right_i > base_i) ? right_i - base_i : base_i - right_i;
    dv   = (pixel_i > base_i) ? pixel_i - base_i : base_i - pixel_i;
    dmax = (dh > dv) ? dh : dv;
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      sq_q   <= SQ_W'(dmax) * SQ_W'(dmax);
      info_q <= info_i;
    end
  end

  // The stage holds its contents until the accumulator takes them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i || (valid_q && !advance_i);
    end
  end

  always_comb begin
    grad_o.valid = valid_q;
    grad_o.sq    = sq_q;
    grad_o.info  = info_q;
  end

endmodule

`default_nettype wire

FILE: sv/bfm_accum.sv
`default_nettype none

module bfm_accum (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire bfm_pkg::grad_t             grad_i,
  output logic                            advance_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [bfm_pkg::SUM_W-1:0]       term_sum_o,
  output logic [bfm_pkg::CNT_W-1:0]       term_count_o,
  output logic                            too_small_o
);
  import bfm_pkg::*;

  logic [SUM_W-1:0] sum_q, total;
  logic [SUM_W-1:0] out_sum_q;
  logic [CNT_W-1:0] out_count_q;
  logic             out_small_q;
  logic             out_valid_q, out_valid_d;

  // A frame end may only move on when the result register is free or is being taken.
  assign advance_o = grad_i.valid &&
                     (!grad_i.info.frame_end || !out_valid_q || out_ready_i);

  assign total = sum_q + (grad_i.info.term_en ? SUM_W'(grad_i.sq) : '0);

  // Running sum, cleared at the end of each frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (advance_o) begin
      sum_q <= grad_i.info.frame_end ? '0 : total;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (advance_o && grad_i.info.frame_end) begin
      out_sum_q   <= grad_i.info.too_small ? '0 : total;
      out_count_q <= grad_i.info.count;
      out_small_q <= grad_i.info.too_small;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (advance_o && grad_i.info.frame_end) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign term_sum_o   = out_sum_q;
  assign term_count_o = out_count_q;
  assign too_small_o  = out_small_q;

  // A frame that is too small reports neither sum nor count.
  a_small_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_small_q |-> (out_sum_q == '0) && (out_count_q == '0))
    else $error("too small frame reports a non-zero result");

  // The sum restarts after each frame end.
  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && grad_i.info.frame_end |=> (sum_q == '0))
    else $error("running sum not cleared at frame end");

  // A pending result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !(advance_o && grad_i.info.frame_end))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: sv/brenner_focus_measure.sv
`default_nettype none

// Brenner focus measure over a stream of 8-bit gray pixels in raster order. One pixel
// transaction is taken per clock; the rate is set by the two line buffers, whose reads
// for the next column are issued in the same cycle as a pixel is taken. For each
// position with at least two columns to its right and two rows below, the larger of the
// distance-two horizontal and vertical differences is squared and summed. On the last
// pixel of a frame one result transaction carries the 40-bit sum, the term count
// (W-2)*(H-2) and a too-small flag (width or height below four, sum and count then zero);
// it passes from the gradient stage into the result register and is held there until it is
// taken. The input stalls only when a further frame end reaches the gradient stage while
// that result is still waiting. Software divides sum by count and by 32512.5 for the final
// measure. Frame width and height are to be written through the configuration port
// between frames; the block itself does not enforce this. Zero is taken as one, and width
// is capped at MAX_WIDTH and height at 4096. The line buffers need no clearing after reset.
module brenner_focus_measure #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bfm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [bfm_pkg::DIM_W-1:0]     cfg_data_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] pixel
  input  wire logic [7:0]                    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [39:0] term_sum, [63:40] term_count
  output logic [63:0]                        m_axis_tdata,
  // [0] too_small
  output logic [0:0]                         m_axis_tuser
);
  import bfm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic             accept, advance;
  logic [AW-1:0]    col, rd_addr, rd_addr2;
  logic [PIX_W-1:0] two_back, two_ahead;
  logic [SUM_W-1:0] term_sum;
  logic [CNT_W-1:0] term_count;
  logic             too_small;
  frame_info_t      info;
  grad_t            grad;

  // The gradient stage takes a pixel whenever it is empty or moving on.
  assign s_axis_tready = !grad.valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  bfm_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .col_o      (col),
    .rd_addr_o  (rd_addr),
    .rd_addr2_o (rd_addr2),
    .info_o     (info)
  );

  bfm_line_buffers #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_lines (
    .clk_i       (clk_i),
    .wr_en_i     (accept),
    .wr_addr_i   (col),
    .pixel_i     (s_axis_tdata),
    .rd_addr_i   (rd_addr),
    .rd_addr2_i  (rd_addr2),
    .two_back_o  (two_back),
    .two_ahead_o (two_ahead)
  );

  bfm_gradient u_grad (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .advance_i (advance),
    .pixel_i   (s_axis_tdata),
    .base_i    (two_back),
    .right_i   (two_ahead),
    .info_i    (info),
    .grad_o    (grad)
  );

  bfm_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .grad_i       (grad),
    .advance_o    (advance),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .term_sum_o   (term_sum),
    .term_count_o (term_count),
    .too_small_o  (too_small)
  );

  assign m_axis_tdata = {term_count, term_sum};
  assign m_axis_tuser = too_small;

endmodule

`default_nettype wire
